/* sv/rcl_pkg.sv */
// Shared types, constants and helper functions of the rotor cipher block.
package rcl_pkg;

  // Alphabet and rotor set.
  localparam int ALPHA   = 26;
  localparam int ROTORS  = 3;
  localparam int LW      = $clog2(ALPHA);
  localparam int FW      = 5;
  localparam int OUT_W   = 8;
  localparam int QDEPTH  = 4;
  localparam int QAW     = $clog2(QDEPTH);

  // Pipeline: plugboard in, rotors forward, reflector, rotors back, plugboard out.
  localparam int NP      = 2 * ROTORS + 2;

  // Commands carried in tuser.
  localparam logic [1:0] CMD_ENCRYPT = 2'd0;
  localparam logic [1:0] CMD_WRITE   = 2'd1;
  localparam logic [1:0] CMD_SETPOS  = 2'd2;
  localparam logic [1:0] CMD_NONE    = 2'd3;

  // Table selectors.
  localparam logic [2:0] SEL_FAST    = 3'd0;
  localparam logic [2:0] SEL_MIDDLE  = 3'd1;
  localparam logic [2:0] SEL_SLOW    = 3'd2;
  localparam logic [2:0] SEL_REFL    = 3'd3;
  localparam logic [2:0] SEL_PLUG    = 3'd4;

  // Queue entry kinds.
  localparam logic KIND_ENC = 1'b0;
  localparam logic KIND_WR  = 1'b1;

  typedef logic [LW-1:0] letter_t;
  typedef logic [FW-1:0] raw_t;
  typedef logic [ROTORS-1:0][LW-1:0] pos_vec_t;

  // Input tdata layout, lowest field last.
  typedef struct packed {
    logic [6:0] pad;
    raw_t       start_slow;
    raw_t       start_middle;
    raw_t       start_fast;
    raw_t       entry_value;
    raw_t       entry_index;
    logic [2:0] table_sel;
    raw_t       letter;
  } in_data_t;

  // One queued operation for the back end.
  typedef struct packed {
    logic       kind;
    letter_t    letter;
    pos_vec_t   pos;
    logic [2:0] sel;
    letter_t    idx;
    raw_t       val;
  } op_t;

  // Reduce a value below twice the alphabet size.
  function automatic letter_t wrap(input logic [LW:0] v);
    logic [LW:0] a;
    a = (LW + 1)'(ALPHA);
    if (v >= a) begin
      wrap = LW'(v - a);
    end else begin
      wrap = LW'(v);
    end
  endfunction

  // Reduce a raw stored or field value.
  function automatic letter_t wrap_raw(input raw_t v);
    wrap_raw = wrap((LW + 1)'(v));
  endfunction

endpackage

/* sv/rcl_front.sv */
// Front end: accepts input beats, keeps rotor positions and queues work for the back end.
module rcl_front
  import rcl_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  input  in_data_t s_data,
  input  logic [1:0] s_cmd,
  input  logic     q_full,
  output logic     q_push,
  output op_t      q_entry
);

  pos_vec_t pos;
  pos_vec_t pos_next;
  pos_vec_t start_pos;
  pos_vec_t step_pos;
  logic     accept;
  logic     wr_ok;
  logic     sel_ok;
  logic     carry;
  raw_t     starts [3];

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  assign starts[0] = s_data.start_fast;
  assign starts[1] = s_data.start_middle;
  assign starts[2] = s_data.start_slow;

  // Odometer step and loaded start positions.
  always_comb begin
    carry    = 1'b1;
    step_pos = pos;
    for (int r = 0; r < ROTORS; r++) begin
      if (carry) begin
        step_pos[r] = wrap((LW + 1)'(pos[r]) + (LW + 1)'(1));
        carry       = (step_pos[r] == '0);
      end
      if (r < 3) begin
        start_pos[r] = wrap_raw(starts[r]);
      end else begin
        start_pos[r] = '0;
      end
    end
  end

  // Table writes that land somewhere are queued, the rest are dropped here.
  always_comb begin
    sel_ok = ((s_data.table_sel < 3'd3) && (32'(s_data.table_sel) < ROTORS)) ||
             (s_data.table_sel == SEL_REFL) || (s_data.table_sel == SEL_PLUG);
    wr_ok  = sel_ok && ((LW + 1)'(s_data.entry_index) < (LW + 1)'(ALPHA));
  end

  // Classify the beat.
  always_comb begin
    pos_next        = pos;
    q_push          = 1'b0;
    q_entry.kind    = KIND_ENC;
    q_entry.letter  = wrap_raw(s_data.letter);
    q_entry.pos     = pos;
    q_entry.sel     = s_data.table_sel;
    q_entry.idx     = LW'(s_data.entry_index);
    q_entry.val     = s_data.entry_value;
    if (accept) begin
      unique case (s_cmd)
        CMD_ENCRYPT: begin
          q_push   = 1'b1;
          pos_next = step_pos;
        end
        CMD_WRITE: begin
          q_push       = wr_ok;
          q_entry.kind = KIND_WR;
        end
        CMD_SETPOS: begin
          pos_next = start_pos;
        end
        CMD_NONE: begin
          q_push = 1'b0;
        end
      endcase
    end
  end

  // Rotor position register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else begin
      pos <= pos_next;
    end
  end

endmodule

/* sv/rcl_queue.sv */
// Short queue of operations between the front and back ends.
module rcl_queue
  import rcl_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  push_data,
  output logic full,
  output logic head_valid,
  output op_t  head,
  input  logic pop
);

  op_t            slots [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;
  logic           do_push;
  logic           do_pop;

  assign full       = (count == (QAW + 1)'(QDEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QAW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (QAW + 1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (QAW + 1)'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

/* sv/rcl_back.sv */
// Back end: wiring tables and the enciphering pipeline with its output register.
module rcl_back
  import rcl_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     head_valid,
  input  op_t      head,
  output logic     pop,
  output logic     m_tvalid,
  input  logic     m_tready,
  output letter_t  m_letter
);

  raw_t     rot_fwd  [ROTORS][ALPHA];
  raw_t     rot_inv  [ROTORS][ALPHA];
  raw_t     refl     [ALPHA];
  raw_t     plug_in  [ALPHA];
  raw_t     plug_out [ALPHA];

  logic     vld   [NP+1];
  letter_t  let_q [NP+1];
  pos_vec_t pos_q [NP-1];

  letter_t  step_in  [NP+1];
  pos_vec_t step_pos [NP+1];
  letter_t  step_out [NP+1];

  logic     adv;
  logic     busy;
  logic     do_write;

  // The whole pipe moves unless a finished beat is held at the output.
  assign adv      = !vld[NP] || m_tready;
  assign m_tvalid = vld[NP];
  assign m_letter = let_q[NP];

  // Any letter still inside the table-reading stages.
  always_comb begin
    busy = 1'b0;
    for (int k = 0; k < NP; k++) begin
      busy = busy | vld[k];
    end
  end

  // Letters pop in step with the pipe; writes wait until no letter reads the tables.
  always_comb begin
    pop = 1'b0;
    if (head_valid) begin
      if (head.kind == KIND_ENC) begin
        pop = adv;
      end else begin
        pop = !busy;
      end
    end
    do_write = head_valid && (head.kind == KIND_WR) && !busy;
  end

  // Stage inputs: the queue head feeds the first stage.
  always_comb begin
    step_in[0]  = head.letter;
    step_pos[0] = head.pos;
    for (int k = 1; k <= NP; k++) begin
      step_in[k] = let_q[k-1];
      if (k <= NP - 1) begin
        step_pos[k] = pos_q[k-1];
      end else begin
        step_pos[k] = '0;
      end
    end
  end

  // One substitution per stage.
  always_comb begin
    letter_t a;
    letter_t o;
    letter_t p;
    int      r;
    a = '0;
    o = '0;
    p = '0;
    r = 0;
    for (int k = 0; k <= NP; k++) begin
      step_out[k] = '0;
      if (k == 0) begin
        step_out[k] = wrap_raw(plug_in[step_in[k]]);
      end else if (k <= ROTORS) begin
        r = k - 1;
        p = step_pos[k][r];
        a = wrap((LW + 1)'(step_in[k]) + (LW + 1)'(p));
        o = wrap_raw(rot_fwd[r][a]);
        step_out[k] = wrap((LW + 1)'(o) + (LW + 1)'(ALPHA) - (LW + 1)'(p));
      end else if (k == ROTORS + 1) begin
        step_out[k] = wrap_raw(refl[step_in[k]]);
      end else if (k <= 2 * ROTORS + 1) begin
        r = 2 * ROTORS + 1 - k;
        p = step_pos[k][r];
        a = wrap((LW + 1)'(step_in[k]) + (LW + 1)'(p));
        o = wrap_raw(rot_inv[r][a]);
        step_out[k] = wrap((LW + 1)'(o) + (LW + 1)'(ALPHA) - (LW + 1)'(p));
      end else begin
        step_out[k] = wrap_raw(plug_out[step_in[k]]);
      end
    end
  end

  // Valid bits of the pipe.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= NP; k++) begin
        vld[k] <= 1'b0;
      end
    end else if (adv) begin
      vld[0] <= head_valid && (head.kind == KIND_ENC);
      for (int k = 1; k <= NP; k++) begin
        vld[k] <= vld[k-1];
      end
    end
  end

  // Letter and position payload of the pipe.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k <= NP; k++) begin
        let_q[k] <= step_out[k];
      end
      for (int k = 0; k < NP - 1; k++) begin
        pos_q[k] <= step_pos[k];
      end
    end
  end

  // Wiring table writes; a rotor write also fills its inverse table.
  always_ff @(posedge clk) begin
    if (do_write) begin
      if (head.sel == SEL_REFL) begin
        refl[head.idx] <= head.val;
      end else if (head.sel == SEL_PLUG) begin
        plug_in[head.idx]  <= head.val;
        plug_out[head.idx] <= head.val;
      end else begin
        for (int r = 0; r < ROTORS; r++) begin
          if (32'(head.sel) == r) begin
            rot_fwd[r][head.idx]           <= head.val;
            rot_inv[r][wrap_raw(head.val)] <= FW'(head.idx);
          end
        end
      end
    end
  end

endmodule

/* sv/rotor_cipher_letter_top.sv */
// Three-rotor letter cipher: stream ports, front end, queue and back end.
// Letters stream through a nine-register pipeline, one beat per cycle while the queue
// has room and the output is not stalled; a result is offered from the last register.
// A table write waits in the queue until letters ahead of it have left the table stages.
// Reset clears the rotor positions to zero, the queue and the pipeline valid bits.
// Wiring tables have no reset and must be written before use.
module rotor_cipher_letter_top
  import rcl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // letter[4:0], table_sel[7:5], entry_index[12:8], entry_value[17:13],
  // start_fast[22:18], start_middle[27:23], start_slow[32:28], zero[39:33]
  input  logic [39:0] s_tdata,
  // cmd[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // cipher_letter[4:0], zero[7:5]
  output logic [7:0]  m_tdata
);

  in_data_t s_data;
  logic     q_full;
  logic     q_push;
  op_t      q_entry;
  logic     head_valid;
  op_t      head;
  logic     pop;
  letter_t  m_letter;

  assign s_data  = in_data_t'(s_tdata);
  assign m_tdata = OUT_W'(m_letter);

  // Beat acceptance and classification.
  rcl_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_data   (s_data),
    .s_cmd    (s_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_entry)
  );

  // Decoupling queue.
  rcl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_entry),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  // Tables and enciphering pipeline.
  rcl_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_letter   (m_letter)
  );

endmodule

/* tb/tb_rotor_cipher_letter_top.sv */
// Self-checking testbench for the three-rotor letter cipher, with a predictor and stream traffic.
`timescale 1ns / 1ps

module tb_rotor_cipher_letter_top;
  import rcl_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_BEATS = 320;
  localparam int DRAIN_CYCLES = 30;

  // One input beat: the command in tuser, the packed fields in tdata.
  typedef struct {
    logic [1:0] cmd;
    in_data_t   data;
    bit         hold;
  } beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic [1:0]  s_tuser = CMD_NONE;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;

  // Stimulus and expectations.
  beat_t      beats_pending[$];
  beat_t      cur_beat;
  logic [4:0] letters_due[$];
  bit         in_fire = 1'b0;

  // Predictor state: wiring, inverse wiring and rotor positions.
  logic [4:0] fwd_map  [ROTORS][ALPHA];
  logic [4:0] back_map [ROTORS][ALPHA];
  logic [4:0] refl_map [ALPHA];
  logic [4:0] plug_map [ALPHA];
  int         rotor_pos[ROTORS];

  // Flow control and bookkeeping.
  int burst_left = 1;
  int gap_left   = 0;
  int ready_mode = 0;
  int ready_left = 0;
  int ready_tick = 0;
  int cycles     = 0;
  int errors     = 0;
  int letters_checked = 0;
  int writes_seen     = 0;
  int loads_seen      = 0;
  int holds_seen      = 0;
  int perm[ALPHA];

  rotor_cipher_letter_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // A beat with every field random; callers override what matters.
  function automatic beat_t rand_beat(input logic [1:0] cmd);
    beat_t       b;
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    b.cmd = cmd;
    b.data = r[39:0];
    b.data.pad = '0;
    b.hold = 1'b0;
    return b;
  endfunction

  function automatic beat_t letter_beat(input int l);
    beat_t b;
    b = rand_beat(CMD_ENCRYPT);
    b.data.letter = 5'(l);
    return b;
  endfunction

  function automatic beat_t write_beat(input logic [2:0] sel, input int idx, input int val);
    beat_t b;
    b = rand_beat(CMD_WRITE);
    b.data.table_sel = sel;
    b.data.entry_index = 5'(idx);
    b.data.entry_value = 5'(val);
    return b;
  endfunction

  function automatic beat_t pos_beat(input int f, input int m, input int s);
    beat_t b;
    b = rand_beat(CMD_SETPOS);
    b.data.start_fast = 5'(f);
    b.data.start_middle = 5'(m);
    b.data.start_slow = 5'(s);
    return b;
  endfunction

  // Queue a full table as a fresh random permutation, so inverse tables stay complete.
  task automatic load_table(input logic [2:0] sel);
    int i;
    int j;
    int t;
    for (i = 0; i < ALPHA; i++) perm[i] = i;
    for (i = ALPHA - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = perm[i];
      perm[i] = perm[j];
      perm[j] = t;
    end
    for (i = 0; i < ALPHA; i++) beats_pending.push_back(write_beat(sel, i, perm[i]));
  endtask

  // One pass through a rotor, forward or through the inverse wiring.
  function automatic int rotor_pass(input int r, input int x, input bit backward);
    int at;
    int o;
    at = (x + rotor_pos[r]) % ALPHA;
    o = backward ? int'(back_map[r][at]) : int'(fwd_map[r][at]);
    return (o % ALPHA + ALPHA - rotor_pos[r]) % ALPHA;
  endfunction

  // Apply an accepted beat to the predictor and queue any cipher letter it yields.
  task automatic track_cipher(input beat_t b);
    int  m;
    int  r;
    int  idx;
    bit  carry;
    case (b.cmd)
      CMD_ENCRYPT: begin
        m = int'(b.data.letter) % ALPHA;
        m = int'(plug_map[m]) % ALPHA;
        for (r = 0; r < ROTORS; r++) m = rotor_pass(r, m, 1'b0);
        m = int'(refl_map[m]) % ALPHA;
        for (r = ROTORS - 1; r >= 0; r--) m = rotor_pass(r, m, 1'b1);
        m = int'(plug_map[m]) % ALPHA;
        letters_due.push_back(5'(m));
        // Odometer step: the fast rotor always moves, carries ripple on a wrap.
        carry = 1'b1;
        for (r = 0; r < ROTORS; r++) begin
          if (carry) begin
            rotor_pos[r] = (rotor_pos[r] + 1) % ALPHA;
            carry = (rotor_pos[r] == 0);
          end
        end
      end
      CMD_WRITE: begin
        writes_seen++;
        idx = int'(b.data.entry_index);
        if (idx < ALPHA) begin
          if (b.data.table_sel <= SEL_SLOW) begin
            fwd_map[b.data.table_sel][idx] = b.data.entry_value;
            back_map[b.data.table_sel][int'(b.data.entry_value) % ALPHA] = 5'(idx);
          end else if (b.data.table_sel == SEL_REFL) begin
            refl_map[idx] = b.data.entry_value;
          end else if (b.data.table_sel == SEL_PLUG) begin
            plug_map[idx] = b.data.entry_value;
          end
        end
      end
      CMD_SETPOS: begin
        loads_seen++;
        rotor_pos[0] = int'(b.data.start_fast) % ALPHA;
        rotor_pos[1] = int'(b.data.start_middle) % ALPHA;
        rotor_pos[2] = int'(b.data.start_slow) % ALPHA;
      end
      default: begin
      end
    endcase
  endtask

  // Sender: bursts of beats with random gaps; a held beat waits for all results.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_fire) begin
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (beats_pending.size() > 0 &&
                   !(beats_pending[0].hold && letters_due.size() > 0)) begin
        cur_beat = beats_pending.pop_front();
        if (cur_beat.hold) holds_seen++;
        s_tvalid <= 1'b1;
        s_tdata  <= cur_beat.data;
        s_tuser  <= cur_beat.cmd;
        if (burst_left <= 1) begin
          if ($urandom_range(0, 7) == 0) begin
            burst_left = $urandom_range(40, 80);
            gap_left = 0;
          end else begin
            burst_left = $urandom_range(1, 12);
            gap_left = $urandom_range(0, 6);
          end
        end else begin
          burst_left--;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern changes between always ready, random, periodic, and sparse.
  always @(negedge clk) begin
    if (ready_left == 0) begin
      ready_mode = $urandom_range(0, 3);
      ready_left = $urandom_range(20, 80);
    end
    ready_left--;
    ready_tick++;
    case (ready_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      2: m_tready <= (ready_tick % 3 == 0);
      default: m_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Monitor: predict on input beats, compare output beats with the oldest expectation.
  always @(posedge clk) begin
    logic [4:0] want;
    in_fire = !rst && s_tvalid && s_tready;
    if (in_fire) track_cipher(cur_beat);
    if (!rst && m_tvalid && m_tready) begin
      if (letters_due.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %0d", $time, m_tdata);
        errors++;
      end else begin
        want = letters_due.pop_front();
        letters_checked++;
        if (m_tdata !== {3'b000, want}) begin
          $display("%0t: cipher_letter wrong, expected %0d, actual %0d",
                   $time, want, m_tdata);
          errors++;
        end
      end
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d beats pending and %0d results due",
               $time, beats_pending.size(), letters_due.size());
      $display("rotor_cipher_letter_top: mismatch");
      $finish;
    end
  end

  // Stimulus and end of run.
  initial begin
    beat_t b;
    int    i;
    int    k;
    int    sel;

    // Every table starts as a full permutation so no unwritten entry is ever read.
    load_table(SEL_FAST);
    load_table(SEL_MIDDLE);
    load_table(SEL_SLOW);
    load_table(SEL_REFL);
    load_table(SEL_PLUG);

    // Directed: letter extremes and out-of-range letters.
    beats_pending.push_back(letter_beat(0));
    beats_pending.push_back(letter_beat(25));
    beats_pending.push_back(letter_beat(26));
    beats_pending.push_back(letter_beat(31));
    // All rotors wrap together, then out-of-range start positions.
    beats_pending.push_back(pos_beat(25, 25, 25));
    beats_pending.push_back(letter_beat(7));
    beats_pending.push_back(letter_beat(7));
    beats_pending.push_back(pos_beat(31, 30, 26));
    beats_pending.push_back(letter_beat(12));
    // Middle rotor carries on the second letter.
    beats_pending.push_back(pos_beat(24, 25, 3));
    beats_pending.push_back(letter_beat(1));
    beats_pending.push_back(letter_beat(1));
    beats_pending.push_back(letter_beat(1));
    // Writes that must be ignored: index past the alphabet, unknown tables.
    beats_pending.push_back(write_beat(SEL_FAST, 26, 7));
    beats_pending.push_back(write_beat(SEL_MIDDLE, 31, 0));
    beats_pending.push_back(write_beat(3'd5, 0, 1));
    beats_pending.push_back(write_beat(3'd6, 12, 2));
    beats_pending.push_back(write_beat(3'd7, 25, 31));
    // Out-of-range stored values, which also break the fast rotor permutation.
    beats_pending.push_back(write_beat(SEL_FAST, 3, 31));
    beats_pending.push_back(write_beat(SEL_REFL, 0, 28));
    beats_pending.push_back(write_beat(SEL_PLUG, 25, 30));
    b = letter_beat(25);
    b.hold = 1'b1;
    beats_pending.push_back(b);
    beats_pending.push_back(letter_beat(3));
    beats_pending.push_back(rand_beat(CMD_NONE));

    // Random traffic, mostly letters, with writes, position loads, no-op beats and table reloads.
    for (i = 0; i < RANDOM_BEATS; i++) begin
      k = $urandom_range(0, 99);
      if (k < 68) begin
        b = letter_beat(($urandom_range(0, 9) == 0) ? $urandom_range(26, 31)
                                                    : $urandom_range(0, 25));
        b.hold = ($urandom_range(0, 99) == 0);
        beats_pending.push_back(b);
      end else if (k < 82) begin
        sel = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
        beats_pending.push_back(write_beat(3'(sel),
            ($urandom_range(0, 9) == 0) ? $urandom_range(26, 31) : $urandom_range(0, 25),
            ($urandom_range(0, 6) == 0) ? $urandom_range(26, 31) : $urandom_range(0, 25)));
      end else if (k < 92) begin
        beats_pending.push_back(pos_beat(
            $urandom_range(0, 1) ? $urandom_range(22, 31) : $urandom_range(0, 31),
            $urandom_range(0, 1) ? $urandom_range(22, 31) : $urandom_range(0, 31),
            $urandom_range(0, 1) ? $urandom_range(22, 31) : $urandom_range(0, 31)));
      end else if (k < 96) begin
        beats_pending.push_back(rand_beat(CMD_NONE));
      end else begin
        load_table(3'($urandom_range(0, 4)));
      end
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (beats_pending.size() > 0 || s_tvalid || letters_due.size() > 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d cipher letters across %0d table writes and %0d position loads,",
             letters_checked, writes_seen, loads_seen);
    $display("with %0d full drains forced mid-stream and varied stall patterns.", holds_seen);
    if (errors == 0) begin
      $display("rotor_cipher_letter_top: match");
    end else begin
      $display("rotor_cipher_letter_top: mismatch");
    end
    $finish;
  end

endmodule
